// ----- rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, constants and helpers for the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES     = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
  localparam int PAGE_W        = $clog2(MAX_PAGES);
  localparam int PAGE_SHIFT    = 12;
  localparam int CNT_W         = 13;
  localparam int ADDR_W        = 24;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] PAGES_MAX = CNT_W'(MAX_PAGES);

  // opcodes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } rsp_t;

  // one access slot of the page map
  typedef struct packed {
    logic                     wr_en;
    logic [WORD_AW-1:0]       wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;
    logic                     rd_en;
    logic [WORD_AW-1:0]       rd_addr;
  } map_cmd_t;

  // bits of map word w that belong to pages below limit
  function automatic logic [MAP_WORD_BITS-1:0] word_mask(
    input logic [WORD_AW-1:0] w,
    input logic [CNT_W-1:0]   limit
  );
    logic [CNT_W-1:0]         lo;
    logic [CNT_W-1:0]         diff;
    logic [MAP_WORD_BITS:0]   ones;
    lo   = CNT_W'({w, {BIT_AW{1'b0}}});
    diff = limit - lo;
    ones = ({{MAP_WORD_BITS{1'b0}}, 1'b1} << diff[BIT_AW:0]) - 1'b1;
    if (limit <= lo) begin
      return '0;
    end else if (diff >= CNT_W'(MAP_WORD_BITS)) begin
      return '1;
    end else begin
      return ones[MAP_WORD_BITS-1:0];
    end
  endfunction

  // index of lowest set bit
  function automatic logic [BIT_AW-1:0] lowest_set(
    input logic [MAP_WORD_BITS-1:0] v
  );
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_AW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bpa_map.sv -----
// ----------------------------------------------------------------------------
// bpa_map
// page bitmap store: ram plus per-word valid bits, unwritten words read zero
// ----------------------------------------------------------------------------
module bpa_map (
  input  logic                              clk,
  input  logic                              rst,
  input  bpa_pkg::map_cmd_t                 cmd,
  output logic [bpa_pkg::MAP_WORD_BITS-1:0] rd_data
);
  import bpa_pkg::*;

  logic [MAP_WORDS-1:0]     valid;
  logic                     rd_ok;
  logic [MAP_WORD_BITS-1:0] ram_q;

  bpa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (cmd.wr_addr),
    .wdata (cmd.wr_data),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_ok <= valid[cmd.rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? ram_q : '0;

endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit physical page allocator, one used bit per 4 KB page
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and must be taken
// then, as the receiver cannot stall. Timing is set by the page map, a ram
// of 128 words of 32 bits with one read per cycle: init writes every map
// word once and then answers; allocate streams map words from word 0 and
// answers once it has found the first free page or read the last managed
// word; an out-of-range free, an allocate with no free pages and the unused
// opcode answer next cycle; an in-range free reads its map word, then clears
// the bit if it is set and answers. busy stays high until the result is
// shown, so one request is in work at a time. After reset the map reads as
// all zero through per-word valid bits, so no clearing pass is needed.
// Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bpa_pkg::req_t                 request,
  output logic                          done,
  output bpa_pkg::rsp_t                 result,
  input  logic                          cfg_write,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_data
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_SCAN = 4'b0100,
    S_FREE = 4'b1000
  } state_t;

  // configuration
  logic [CNT_W-1:0] page_count;
  logic [CNT_W-1:0] reserved_pages;

  // control and counts
  state_t             state, state_next;
  logic [WORD_AW:0]   word_idx, word_idx_next;     // sweep / read issue pointer
  logic               rd_pending, rd_pending_next; // map data due this cycle
  logic [WORD_AW-1:0] rd_word, rd_word_next;       // word of the returning data
  logic [BIT_AW-1:0]  free_bit, free_bit_next;
  logic [CNT_W-1:0]   pages_held, pages_held_next;
  logic [CNT_W-1:0]   pages_spare, pages_spare_next;
  logic               done_next;
  rsp_t               result_next;

  map_cmd_t                 map_cmd;
  logic [MAP_WORD_BITS-1:0] map_q;

  // derived from configuration
  logic [CNT_W-1:0]         count_eff;
  logic [CNT_W-1:0]         res_eff;
  logic [CNT_W-1:0]         count_m1;
  logic [WORD_AW-1:0]       last_word;
  logic [19:0]              req_page;
  logic [MAP_WORD_BITS-1:0] avail;
  logic [BIT_AW-1:0]        hit_bit;
  logic [MAP_WORD_BITS-1:0] bit_sel;
  logic                     accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign count_eff = (page_count > PAGES_MAX) ? PAGES_MAX : page_count;
  assign res_eff   = (reserved_pages > count_eff) ? count_eff : reserved_pages;
  assign count_m1  = count_eff - 1'b1;
  assign last_word = count_m1[PAGE_W-1:BIT_AW];
  assign req_page  = request.free_address[31:PAGE_SHIFT];

  // free pages within the returned word, and the first of them
  assign avail   = ~map_q & word_mask(rd_word, count_eff);
  assign hit_bit = lowest_set(avail);
  assign bit_sel = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << (state == S_FREE ? free_bit : hit_bit);

  bpa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .cmd     (map_cmd),
    .rd_data (map_q)
  );

  always_comb begin
    state_next       = state;
    word_idx_next    = word_idx;
    rd_pending_next  = 1'b0;
    rd_word_next     = rd_word;
    free_bit_next    = free_bit;
    pages_held_next  = pages_held;
    pages_spare_next = pages_spare;
    done_next        = 1'b0;
    result_next      = result;
    map_cmd          = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.opcode)
            OP_INIT: begin
              // counts are known at once; the map is rewritten by the sweep
              pages_held_next  = res_eff;
              pages_spare_next = count_eff - res_eff;
              word_idx_next    = '0;
              state_next       = S_INIT;
            end
            OP_ALLOC: begin
              if (pages_spare == '0 || count_eff == '0) begin
                done_next   = 1'b1;
                result_next = '{ST_OOM, '0, pages_held, pages_spare};
              end else begin
                word_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
            OP_FREE: begin
              if (req_page < {7'd0, count_eff}) begin
                map_cmd.rd_en   = 1'b1;
                map_cmd.rd_addr = req_page[PAGE_W-1:BIT_AW];
                rd_word_next    = req_page[PAGE_W-1:BIT_AW];
                free_bit_next   = req_page[BIT_AW-1:0];
                state_next      = S_FREE;
              end else begin
                done_next   = 1'b1;
                result_next = '{ST_IGNORED, '0, pages_held, pages_spare};
              end
            end
            default: begin
              done_next   = 1'b1;
              result_next = '{ST_DONE, '0, pages_held, pages_spare};
            end
          endcase
        end
      end

      S_INIT: begin
        // one map word per cycle: reserved pages set, the rest clear
        map_cmd.wr_en   = 1'b1;
        map_cmd.wr_addr = word_idx[WORD_AW-1:0];
        map_cmd.wr_data = word_mask(word_idx[WORD_AW-1:0], res_eff);
        word_idx_next   = word_idx + 1'b1;
        if (word_idx[WORD_AW-1:0] == WORD_AW'(MAP_WORDS - 1)) begin
          done_next   = 1'b1;
          result_next = '{ST_DONE, '0, pages_held, pages_spare};
          state_next  = S_IDLE;
        end
      end

      S_SCAN: begin
        if (rd_pending && avail != '0) begin
          // first free page found: claim it and stop
          map_cmd.wr_en    = 1'b1;
          map_cmd.wr_addr  = rd_word;
          map_cmd.wr_data  = map_q | bit_sel;
          pages_held_next  = (pages_held < CNT_MAX) ? pages_held + 1'b1 : pages_held;
          pages_spare_next = pages_spare - 1'b1;
          done_next        = 1'b1;
          result_next      = '{ST_DONE, ADDR_W'({rd_word, hit_bit, {PAGE_SHIFT{1'b0}}}),
                               pages_held_next, pages_spare_next};
          state_next       = S_IDLE;
        end else if (rd_pending && rd_word == last_word) begin
          // map exhausted although the counts said otherwise
          done_next   = 1'b1;
          result_next = '{ST_OOM, '0, pages_held, pages_spare};
          state_next  = S_IDLE;
        end else if (word_idx <= {1'b0, last_word}) begin
          // keep one word read in flight each cycle
          map_cmd.rd_en   = 1'b1;
          map_cmd.rd_addr = word_idx[WORD_AW-1:0];
          rd_word_next    = word_idx[WORD_AW-1:0];
          rd_pending_next = 1'b1;
          word_idx_next   = word_idx + 1'b1;
        end
      end

      S_FREE: begin
        if (map_q[free_bit]) begin
          map_cmd.wr_en    = 1'b1;
          map_cmd.wr_addr  = rd_word;
          map_cmd.wr_data  = map_q & ~bit_sel;
          pages_held_next  = (pages_held != '0) ? pages_held - 1'b1 : pages_held;
          pages_spare_next = (pages_spare < CNT_MAX) ? pages_spare + 1'b1 : pages_spare;
          result_next      = '{ST_DONE, '0, pages_held_next, pages_spare_next};
        end else begin
          result_next      = '{ST_IGNORED, '0, pages_held, pages_spare};
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rd_pending     <= 1'b0;
      done           <= 1'b0;
      pages_held     <= '0;
      pages_spare    <= '0;
      page_count     <= PAGES_MAX;
      reserved_pages <= CNT_W'(257);
    end else begin
      state       <= state_next;
      rd_pending  <= rd_pending_next;
      done        <= done_next;
      pages_held  <= pages_held_next;
      pages_spare <= pages_spare_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_PAGE_COUNT: page_count     <= cfg_data;
          CFG_RESERVED:   reserved_pages <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_idx <= word_idx_next;
    rd_word  <= rd_word_next;
    free_bit <= free_bit_next;
    result   <= result_next;
  end

endmodule

// ----- tb/bitmap_page_allocator_test.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_test
// self-checking bench for the first-fit bitmap page allocator
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge. Every request taken and every
// result shown is seen on the rising edge. A ledger object keeps its own copy
// of the page map, the counts and the two registers. It works out the reply
// owed for each request taken and checks each result against the oldest reply
// still owed. The run has a short directed part and then random traffic in
// three rounds of sender idling. Between groups of requests the registers are
// rewritten while the block is quiet.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_test;

  import bpa_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // quiet cycles before giving up
  localparam int TAIL_CYCLES   = 140;   // longest allocate plus margin
  localparam int ROUND_ITEMS   = 508;   // random requests per idling round
  localparam int REPORT_LIMIT  = 10;

  // --------------------------------------------------------------------------
  // ledger: mirror of the allocator state and the replies still owed
  // --------------------------------------------------------------------------
  class alloc_ledger;
    bit               used_map [MAX_PAGES];
    logic [CNT_W-1:0] pages_held   = '0;
    logic [CNT_W-1:0] pages_spare  = '0;
    logic [CNT_W-1:0] page_count   = CNT_W'(4096);
    logic [CNT_W-1:0] reserved_cnt = CNT_W'(257);
    rsp_t             owed_replies [$];
    int               mismatches   = 0;
    int               replies_seen = 0;
    int               status_seen  [4];

    function int unsigned managed();
      return (page_count > PAGES_MAX) ? MAX_PAGES : int'(page_count);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      if (idx == CFG_PAGE_COUNT) begin
        page_count = val;
      end else begin
        reserved_cnt = val;
      end
    endfunction

    // work out the reply owed for a request that has just been taken
    function void book_request(req_t rq);
      rsp_t        owed;
      int unsigned lim;
      int unsigned keep;
      int unsigned pg;
      bit          found;
      lim   = managed();
      owed  = '0;
      found = 1'b0;
      owed.status = ST_DONE;
      case (rq.opcode)
        OP_INIT: begin
          keep = (reserved_cnt > lim) ? lim : int'(reserved_cnt);
          foreach (used_map[i]) used_map[i] = (i < keep);
          pages_held  = CNT_W'(keep);
          pages_spare = CNT_W'(lim - keep);
        end
        OP_ALLOC: begin
          owed.status = ST_OOM;
          if (pages_spare != 0) begin
            for (int unsigned p = 0; p < lim; p++) begin
              if (!found && !used_map[p]) begin
                found       = 1'b1;
                used_map[p] = 1'b1;
                if (pages_held < CNT_MAX) pages_held++;
                pages_spare--;
                owed.page_address = ADDR_W'(p << PAGE_SHIFT);
                owed.status       = ST_DONE;
              end
            end
          end
        end
        OP_FREE: begin
          pg = rq.free_address >> PAGE_SHIFT;
          if (pg < lim && used_map[pg]) begin
            used_map[pg] = 1'b0;
            if (pages_held != 0) pages_held--;
            if (pages_spare < CNT_MAX) pages_spare++;
          end else begin
            owed.status = ST_IGNORED;
          end
        end
        default: ;
      endcase
      owed.used_count = pages_held;
      owed.free_count = pages_spare;
      owed_replies.push_back(owed);
    endfunction

    function void note_failure(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
    endfunction

    // compare a result field by field with the oldest reply owed
    function void settle_reply(rsp_t got);
      rsp_t owed;
      replies_seen++;
      if (owed_replies.size() == 0) begin
        note_failure($sformatf({"result with no request waiting:",
                                " status %0d addr %h used %0d free %0d"},
                               got.status, got.page_address, got.used_count,
                               got.free_count));
      end else begin
        owed = owed_replies.pop_front();
        status_seen[owed.status]++;
        if (got.status !== owed.status || got.page_address !== owed.page_address ||
            got.used_count !== owed.used_count || got.free_count !== owed.free_count) begin
          note_failure($sformatf({"mismatch: expected status %0d addr %h used %0d free %0d,",
                                  " got status %0d addr %h used %0d free %0d"},
                                 owed.status, owed.page_address, owed.used_count,
                                 owed.free_count, got.status, got.page_address,
                                 got.used_count, got.free_count));
        end
      end
    endfunction

    // some page marked used below the managed limit, or -1 if none
    function int random_used_page();
      int unsigned lim;
      int unsigned first;
      int unsigned p;
      lim = managed();
      if (lim == 0) return -1;
      first = $urandom_range(lim - 1, 0);
      for (int unsigned k = 0; k < lim; k++) begin
        p = (first + k) % lim;
        if (used_map[p]) return int'(p);
      end
      return -1;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 request;
  logic                 done;
  rsp_t                 result;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  alloc_ledger ledger;
  int          sender_idle_pct;
  int          quiet_cycles = 0;
  int          settings_used;

  bitmap_page_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // observers: everything is sampled on the rising edge, before the block
  // updates, so register writes, requests and results are seen as taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) ledger.write_reg(cfg_index, cfg_data);
      if (start && !busy) ledger.book_request(request);
      if (done) ledger.settle_reply(result);
    end
  end

  // watchdog: a run of cycles with no request, result or write taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles, %0d replies still owed",
                 $time, quiet_cycles, ledger.owed_replies.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers, all entered and left on a falling edge
  // --------------------------------------------------------------------------
  function automatic req_t make_request(logic [1:0] op, logic [31:0] addr);
    req_t rq;
    rq.opcode       = op;
    rq.free_address = addr;
    return rq;
  endfunction

  // offer one request, idling the sender a cycle at a time first
  task automatic issue(req_t rq);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off until every owed reply has come back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (ledger.owed_replies.size() != 0 || busy);
  endtask

  // write both registers on consecutive cycles
  task automatic set_config(logic [CNT_W-1:0] pages, logic [CNT_W-1:0] reserved);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PAGE_COUNT;
    cfg_data  <= pages;
    @(negedge clk);
    cfg_index <= CFG_RESERVED;
    cfg_data  <= reserved;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          sent;
    int          run_len;
    int          pick;
    int          pg;
    int unsigned lim;
    int unsigned pages;
    int unsigned reserved;
    logic [31:0] addr;

    ledger        = new();
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_PAGE_COUNT;
    cfg_data      = '0;
    settings_used = 0;
    sender_idle_pct = 26;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // untouched map: allocate is refused, a free is ignored, spare opcode idles
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_FREE, 32'h0000_1000));
    issue(make_request(OP_NOP, 32'hFFFF_FFFF));

    // reset registers: 4096 pages with the low 257 held back
    issue(make_request(OP_INIT, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_FREE, 32'h0010_1FFF));   // page offset is dropped
    issue(make_request(OP_FREE, 32'h0010_1000));   // same page twice
    issue(make_request(OP_FREE, 32'hFFFF_FFFF));   // far beyond the map
    issue(make_request(OP_FREE, 32'h0000_0ABC));   // reserved page released
    issue(make_request(OP_ALLOC, 32'h0));          // first fit picks page 0

    // page count above the map size, reserve above the count
    drain();
    set_config(CNT_MAX, CNT_MAX);
    issue(make_request(OP_INIT, 32'h0));
    issue(make_request(OP_FREE, 32'h00FF_F000));   // top page
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));

    // nothing managed at all
    drain();
    set_config('0, '0);
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_INIT, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));

    // a single page
    drain();
    set_config(CNT_W'(1), '0);
    issue(make_request(OP_INIT, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));

    // shrink the count after init: counts stay, search and range test follow it
    drain();
    set_config(PAGES_MAX, '0);
    issue(make_request(OP_INIT, 32'h0));
    drain();
    set_config(CNT_W'(2), '0);
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_ALLOC, 32'h0));
    issue(make_request(OP_FREE, 32'h0006_4000));

    // random traffic: sender idles now and then, then often, then never
    for (int round = 0; round < 3; round++) begin
      sender_idle_pct = (round == 0) ? 26 : (round == 1) ? 77 : 0;
      sent = 0;
      while (sent < ROUND_ITEMS) begin
        // fresh register setting, mostly small page counts to keep scans short
        case ($urandom_range(9))
          0:       pages = 0;
          1:       pages = $urandom_range(8191, 4097);
          2:       pages = MAX_PAGES;
          3, 4, 8: pages = $urandom_range(64, 1);
          5, 6:    pages = $urandom_range(4096, 65);
          7:       pages = 1;
          default: pages = $urandom_range(8191, 0);
        endcase
        case ($urandom_range(9))
          0:       reserved = 0;
          1:       reserved = (pages > 8191) ? 8191 : pages;
          2:       reserved = 8191;
          3:       reserved = $urandom_range(8191, 0);
          4:       reserved = 257;
          default: reserved = $urandom_range(pages > 4096 ? 4096 : pages, 0);
        endcase
        drain();
        set_config(CNT_W'(pages), CNT_W'(reserved));
        // mostly a clean init first; sometimes keep the old map and counts
        if ($urandom_range(4) != 0) begin
          issue(make_request(OP_INIT, $urandom));
          sent++;
        end
        run_len = $urandom_range(80, 20);
        if (run_len > ROUND_ITEMS - sent) run_len = ROUND_ITEMS - sent;
        repeat (run_len) begin
          // now and then let every owed reply come back before going on
          if ($urandom_range(99) < 3) drain();
          lim  = ledger.managed();
          pick = $urandom_range(99);
          addr = $urandom;
          if (pick < 4) begin
            issue(make_request(OP_INIT, addr));
          end else if (pick < 50) begin
            issue(make_request(OP_ALLOC, addr));
          end else if (pick < 78) begin
            // release a page known to be held, keeping a random offset
            pg = ledger.random_used_page();
            if (pg >= 0) addr = {8'h00, 12'(pg), addr[11:0]};
            issue(make_request(OP_FREE, addr));
          end else if (pick < 88) begin
            // page around the managed limit, held or not
            pg   = $urandom_range(lim + 8, 0);
            addr = {pg[19:0], addr[11:0]};
            issue(make_request(OP_FREE, addr));
          end else if (pick < 96) begin
            issue(make_request(OP_FREE, addr));
          end else begin
            issue(make_request(OP_NOP, addr));
          end
          sent++;
        end
      end
    end

    // wind down: every reply in, then a quiet tail to catch strays
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (ledger.owed_replies.size() != 0) begin
      ledger.note_failure($sformatf("%0d replies never arrived", ledger.owed_replies.size()));
    end

    $display("covered %0d replies over %0d register settings", ledger.replies_seen,
             settings_used);
    $display("status done %0d, out of memory %0d, free ignored %0d; %0d failures",
             ledger.status_seen[ST_DONE], ledger.status_seen[ST_OOM],
             ledger.status_seen[ST_IGNORED], ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
